// ===== hw/rtl/tcw_pkg.sv =====
// shared constants, types and helper functions for the text console writer
// no dependencies; imported by every module of the block but tcw_ram
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 2 * CHAR_W;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS + 2);
  localparam int TOP_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int RSHIFT   = POS_W + $clog2(COLUMNS);
  localparam int RECIP    = ((1 << RSHIFT) + COLUMNS - 1) / COLUMNS;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = POS_W + RECIP_W;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BLANK_ATTR = REG_IDX_W'(0);

  localparam logic [CHAR_W-1:0] SPACE_CH     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CH   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSLASH_CH = 8'h5C;
  localparam logic [CHAR_W-1:0] LETTER_N     = 8'h6E;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN_NL = 3'd0,
    KIND_BEGIN_SL = 3'd1,
    KIND_CHAR     = 3'd2,
    KIND_END      = 3'd3,
    KIND_SET      = 3'd4,
    KIND_READ     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] color;
    logic [ROW_W-1:0]  prow;
    logic [COL_W-1:0]  pcol;
    logic              poob;
    logic              is_n;
    logic              is_bs;
    logic              is_nl;
  } item_t;

  // row of a logical index, reciprocal multiply (exact over the whole index range)
  function automatic logic [ROW_W-1:0] pos_row(input logic [POS_W-1:0] pos);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(pos) * PROD_W'(RECIP);
    return ROW_W'(prod >> RSHIFT);
  endfunction

  function automatic logic [COL_W-1:0] pos_col(input logic [POS_W-1:0] pos,
                                               input logic [ROW_W-1:0] row);
    logic [POS_W-1:0] base;
    base = POS_W'(row) * POS_W'(COLUMNS);
    return COL_W'(pos - base);
  endfunction

  // logical row to ring row
  function automatic logic [TOP_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                input logic [TOP_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + (ROW_W + 1)'(top);
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return TOP_W'(sum);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [TOP_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  function automatic logic [POS_W-1:0] cursor_of(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
  endfunction

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/tcw_front.sv =====
// front end: takes input items, splits the position into row and column and
// decodes the character class; depends on tcw_pkg
module tcw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tcw_pkg::KIND_W-1:0] in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0] in_ch,
  input  logic [tcw_pkg::CHAR_W-1:0] in_color,
  input  logic [tcw_pkg::POS_W-1:0]  in_position,
  input  logic                       hold,
  input  logic                       q_full,
  output logic                       q_push,
  output tcw_pkg::item_t             q_item
);
  import tcw_pkg::*;

  logic              v_r, v_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [CHAR_W-1:0] ch_r;
  logic [CHAR_W-1:0] color_r;
  logic [POS_W-1:0]  pos_r;
  logic [ROW_W-1:0]  row_r;
  logic              accept;
  logic              oob;

  assign in_ready = !hold && (!v_r || !q_full);
  assign accept   = in_valid && in_ready;
  assign q_push   = v_r && !q_full;

  always_comb begin
    v_nxt = v_r;
    if (accept) begin
      v_nxt = 1'b1;
    end else if (q_push) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      ch_r    <= in_ch;
      color_r <= in_color;
      pos_r   <= in_position;
      row_r   <= pos_row(in_position);
    end
  end

  assign oob = (pos_r >= POS_W'(CELLS));

  always_comb begin
    q_item.kind  = kind_t'(kind_r);
    q_item.ch    = ch_r;
    q_item.color = color_r;
    q_item.poob  = oob;
    q_item.prow  = oob ? ROW_W'(ROWS) : row_r;
    q_item.pcol  = oob ? '0 : pos_col(pos_r, row_r);
    q_item.is_n  = (ch_r == LETTER_N);
    q_item.is_bs = (ch_r == BACKSLASH_CH);
    q_item.is_nl = (ch_r == NEWLINE_CH);
  end

endmodule

// ===== hw/rtl/tcw_fifo.sv =====
// short item queue between the front end and the back end
// depends on tcw_pkg
module tcw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcw_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tcw_pkg::item_t head
);
  import tcw_pkg::*;

  item_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, wp_nxt;
  logic [QPTR_W-1:0]  rp_r, rp_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// back end: cursor, ring offset and string state; carries out each item on the
// screen memory, runs the reset clear and the row blanking; depends on tcw_pkg
module tcw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tcw_pkg::item_t             q_item,
  output logic                       q_pop,
  input  logic [tcw_pkg::CHAR_W-1:0] blank_attr,
  output logic                       clearing,
  output logic                       ram_we,
  output logic [tcw_pkg::ADDR_W-1:0] ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic [tcw_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tcw_pkg::POS_W-1:0]  out_cursor_now,
  output logic [tcw_pkg::CHAR_W-1:0] out_read_char,
  output logic [tcw_pkg::CHAR_W-1:0] out_read_attr,
  output logic                       out_scrolled,
  output logic                       out_dropped
);
  import tcw_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_READ   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  item_t             it_r, it_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic              same_r, same_nxt;
  logic              held_r, held_nxt;
  logic [CHAR_W-1:0] hcolor_r, hcolor_nxt;
  logic [TOP_W-1:0]  sw_row_r, sw_row_nxt;
  logic [COL_W-1:0]  sw_col_r, sw_col_nxt;
  logic              ret_done_r, ret_done_nxt;
  logic              scr_r, scr_nxt;

  logic              out_v_r, out_v_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [CHAR_W-1:0] out_rch_r, out_rch_nxt;
  logic [CHAR_W-1:0] out_rat_r, out_rat_nxt;
  logic              out_scr_r, out_scr_nxt;
  logic              out_drp_r, out_drp_nxt;

  logic              out_free;
  logic              at_end;
  logic              last_col;
  logic [TOP_W-1:0]  wrow;
  logic [COL_W-1:0]  wcol;
  logic              do_put;
  logic              do_nl;
  logic [CHAR_W-1:0] put_ch;
  logic [CHAR_W-1:0] put_at;
  logic              fin;
  logic              drop;

  assign out_free = !out_v_r || out_ready;
  assign clearing = (state_r == ST_CLEAR);
  assign at_end   = (row_r == ROW_W'(ROWS)) ||
                    ((row_r == ROW_W'(ROWS - 1)) && (col_r == COL_W'(COLUMNS - 1)));
  assign last_col = (sw_col_r == COL_W'(COLUMNS - 1));

  assign ram_waddr = cell_addr(wrow, wcol);
  assign ram_raddr = cell_addr(phys_row(it_r.prow, top_r), it_r.pcol);

  always_comb begin
    state_nxt    = state_r;
    it_nxt       = it_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    same_nxt     = same_r;
    held_nxt     = held_r;
    hcolor_nxt   = hcolor_r;
    sw_row_nxt   = sw_row_r;
    sw_col_nxt   = sw_col_r;
    ret_done_nxt = ret_done_r;
    scr_nxt      = scr_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_rch_nxt  = out_rch_r;
    out_rat_nxt  = out_rat_r;
    out_scr_nxt  = out_scr_r;
    out_drp_nxt  = out_drp_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    wrow         = phys_row(row_r, top_r);
    wcol         = col_r;
    ram_wdata    = {RESET_ATTR, SPACE_CH};
    do_put       = 1'b0;
    do_nl        = 1'b0;
    put_ch       = BACKSLASH_CH;
    put_at       = hcolor_r;
    fin          = 1'b0;
    drop         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        wrow   = sw_row_r;
        wcol   = sw_col_r;
        if (last_col) begin
          sw_col_nxt = '0;
          if (sw_row_r == TOP_W'(ROWS - 1)) begin
            sw_row_nxt = '0;
            state_nxt  = ST_IDLE;
          end else begin
            sw_row_nxt = sw_row_r + 1'b1;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop     = 1'b1;
          it_nxt    = q_item;
          scr_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (it_r.kind)
          KIND_BEGIN_NL: begin
            row_nxt  = (row_r >= ROW_W'(ROWS)) ? ROW_W'(ROWS) : row_r + 1'b1;
            col_nxt  = '0;
            same_nxt = 1'b0;
            held_nxt = 1'b0;
            fin      = 1'b1;
          end
          KIND_BEGIN_SL: begin
            same_nxt = 1'b1;
            held_nxt = 1'b0;
            fin      = 1'b1;
          end
          KIND_CHAR: begin
            if (held_r) begin
              held_nxt = 1'b0;
              if (it_r.is_n) begin
                do_nl = 1'b1;
                fin   = 1'b1;
              end else begin
                // held backslash goes out first, the item itself is carried out after it
                do_put = 1'b1;
              end
            end else if (same_r && at_end) begin
              drop = 1'b1;
              fin  = 1'b1;
            end else if (it_r.is_bs) begin
              held_nxt   = 1'b1;
              hcolor_nxt = it_r.color;
              fin        = 1'b1;
            end else if (it_r.is_nl) begin
              do_nl = 1'b1;
              fin   = 1'b1;
            end else begin
              do_put = 1'b1;
              put_ch = it_r.ch;
              put_at = it_r.color;
              fin    = 1'b1;
            end
          end
          KIND_END: begin
            if (held_r) begin
              held_nxt = 1'b0;
              do_put   = 1'b1;
            end
            fin = 1'b1;
          end
          KIND_SET: begin
            row_nxt  = it_r.prow;
            col_nxt  = it_r.pcol;
            held_nxt = 1'b0;
            fin      = 1'b1;
          end
          KIND_READ: begin
            if (it_r.poob) begin
              fin = 1'b1;
            end else begin
              state_nxt = ST_READ;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        if (do_put) begin
          if (!same_r && (row_r == ROW_W'(ROWS))) begin
            // scroll first, then run this item again with the held state kept and the cursor one row up
            held_nxt     = held_r;
            fin          = 1'b0;
            state_nxt    = ST_SCROLL;
            ret_done_nxt = 1'b0;
            scr_nxt      = 1'b1;
          end else if (!same_r || !at_end) begin
            ram_we    = 1'b1;
            ram_wdata = {put_at, put_ch};
            if (col_r == COL_W'(COLUMNS - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end

        if (do_nl) begin
          col_nxt = '0;
          if (!same_r && (row_r >= ROW_W'(ROWS - 1))) begin
            fin          = 1'b0;
            state_nxt    = ST_SCROLL;
            ret_done_nxt = 1'b1;
            scr_nxt      = 1'b1;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end

      ST_SCROLL: begin
        // blank the old top row, which becomes the new bottom row
        ram_we    = 1'b1;
        wrow      = top_r;
        wcol      = sw_col_r;
        ram_wdata = {blank_attr, SPACE_CH};
        if (last_col) begin
          sw_col_nxt = '0;
          top_nxt    = (top_r == TOP_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
          if (ret_done_r) begin
            fin = 1'b1;
          end else begin
            row_nxt   = row_r - 1'b1;
            state_nxt = ST_EXEC;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end

      ST_READ: begin
        fin = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt   = ST_IDLE;
      out_v_nxt   = 1'b1;
      out_row_nxt = row_nxt;
      out_col_nxt = col_nxt;
      out_rch_nxt = (state_r == ST_READ) ? ram_rdata[CHAR_W-1:0] : '0;
      out_rat_nxt = (state_r == ST_READ) ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      out_scr_nxt = scr_nxt;
      out_drp_nxt = drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      row_r      <= '0;
      col_r      <= '0;
      top_r      <= '0;
      same_r     <= 1'b0;
      held_r     <= 1'b0;
      hcolor_r   <= '0;
      sw_row_r   <= '0;
      sw_col_r   <= '0;
      ret_done_r <= 1'b0;
      scr_r      <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      top_r      <= top_nxt;
      same_r     <= same_nxt;
      held_r     <= held_nxt;
      hcolor_r   <= hcolor_nxt;
      sw_row_r   <= sw_row_nxt;
      sw_col_r   <= sw_col_nxt;
      ret_done_r <= ret_done_nxt;
      scr_r      <= scr_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r      <= it_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_rch_r <= out_rch_nxt;
    out_rat_r <= out_rat_nxt;
    out_scr_r <= out_scr_nxt;
    out_drp_r <= out_drp_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_cursor_now = cursor_of(out_row_r, out_col_r);
  assign out_read_char  = out_rch_r;
  assign out_read_attr  = out_rat_r;
  assign out_scrolled   = out_scr_r;
  assign out_dropped    = out_drp_r;

endmodule

// ===== hw/rtl/text_console_writer_unit.sv =====
// path: an item is registered in the front end, pushed into the queue, popped in
// ST_IDLE while the output is free, carried out in ST_EXEC, and its result is
// registered at the output; the back end handles one item at a time. A character
// other than n after a held backslash runs ST_EXEC again once the backslash is out,
// an on-screen read adds ST_READ; a scroll adds ST_SCROLL, then ST_EXEC on a rerun
// reset: ST_CLEAR blanks every cell, no item is taken meanwhile; configuration
// writes are taken as ever; depends on tcw_pkg, tcw_front, tcw_fifo, tcw_back, tcw_ram
module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]  in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_ch,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_color,
  input  logic [tcw_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_now,
  output logic [tcw_pkg::CHAR_W-1:0]  out_read_char,
  output logic [tcw_pkg::CHAR_W-1:0]  out_read_attr,
  output logic                        out_scrolled,
  output logic                        out_dropped,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0]    blank_attr_r, blank_attr_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 clearing;
  logic                 q_full;
  logic                 q_push;
  item_t                q_in;
  logic                 q_pop;
  logic                 q_valid;
  item_t                q_head;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CELL_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [CELL_W-1:0]    ram_rdata;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_BLANK_ATTR) ? PDATA_W'(blank_attr_r) : '0;

  always_comb begin
    blank_attr_nxt = blank_attr_r;
    if (cfg_wr && (reg_idx == REG_BLANK_ATTR)) begin
      blank_attr_nxt = pwdata[CHAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_attr_r <= RESET_ATTR;
    end else begin
      blank_attr_r <= blank_attr_nxt;
    end
  end

  tcw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_ch       (in_ch),
    .in_color    (in_color),
    .in_position (in_position),
    .hold        (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  tcw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_head),
    .q_pop          (q_pop),
    .blank_attr     (blank_attr_r),
    .clearing       (clearing),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_now (out_cursor_now),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr),
    .out_scrolled   (out_scrolled),
    .out_dropped    (out_dropped)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== tb/text_console_writer_unit_test.sv =====
// self-checking testbench for the text console writer: directed and random items,
// results predicted from its own copy of the screen, cursor and string state
// depends on tcw_pkg and text_console_writer_unit
`timescale 1ns / 100ps

module text_console_writer_unit_test;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 440;
  localparam int MAX_PRINTED = 40;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [PADDR_W-1:0] BLANK_ATTR_ADDR = {REG_BLANK_ATTR, 2'b00};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] color;
    logic [POS_W-1:0]  pos;
  } console_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] rchar;
    logic [CHAR_W-1:0] rattr;
    logic              scrolled;
    logic              dropped;
  } console_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [CHAR_W-1:0] in_ch = '0;
  logic [CHAR_W-1:0] in_color = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] out_cursor_now;
  logic [CHAR_W-1:0] out_read_char;
  logic [CHAR_W-1:0] out_read_attr;
  logic out_scrolled;
  logic out_dropped;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  text_console_writer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_ch(in_ch),
    .in_color(in_color), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_cursor_now(out_cursor_now),
    .out_read_char(out_read_char), .out_read_attr(out_read_attr),
    .out_scrolled(out_scrolled), .out_dropped(out_dropped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // predicted console state
  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned top_row;
  int unsigned cursor_pos;
  bit same_line;
  bit bs_held;
  logic [CHAR_W-1:0] bs_color;
  logic [CHAR_W-1:0] blank_attr;
  bit scroll_hit;

  console_item_t pending_items[$];
  console_result_t due_results[$];
  int items_taken = 0;
  int results_checked = 0;
  int queued_count = 0;
  int sent_count = 0;
  int mismatch_count = 0;
  int scroll_total = 0;
  int drop_total = 0;
  int read_total = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit drain_wait = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic int unsigned ring_index(input int unsigned logical);
    return ((logical / COLUMNS + top_row) % ROWS) * COLUMNS + logical % COLUMNS;
  endfunction

  function automatic void store_cell(input int unsigned logical, input logic [CHAR_W-1:0] chr,
                                     input logic [CHAR_W-1:0] attr);
    if (logical < CELLS) begin
      screen_mem[ring_index(logical)] = {attr, chr};
    end
  endfunction

  function automatic void scroll_row();
    int unsigned base;
    top_row = (top_row + 1) % ROWS;
    base = ((top_row + ROWS - 1) % ROWS) * COLUMNS;
    for (int c = 0; c < COLUMNS; c++) begin
      screen_mem[base + c] = {blank_attr, SPACE_CH};
    end
    scroll_hit = 1'b1;
  endfunction

  function automatic void put_scrolling(input logic [CHAR_W-1:0] chr,
                                        input logic [CHAR_W-1:0] attr);
    if (cursor_pos >= CELLS) begin
      scroll_row();
      cursor_pos -= COLUMNS;
    end
    store_cell(cursor_pos, chr, attr);
    cursor_pos++;
  endfunction

  function automatic void line_feed_scrolling();
    cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
    if (cursor_pos >= CELLS) begin
      scroll_row();
      cursor_pos -= COLUMNS;
    end
  endfunction

  function automatic void put_clipped(input logic [CHAR_W-1:0] chr,
                                      input logic [CHAR_W-1:0] attr);
    if (cursor_pos < CELLS - 1) begin
      store_cell(cursor_pos, chr, attr);
      cursor_pos++;
    end
  endfunction

  function automatic console_result_t console_step(input console_item_t it);
    console_result_t res;
    logic [CELL_W-1:0] entry;
    bit done;
    bit drop;
    res = '0;
    done = 1'b0;
    drop = 1'b0;
    scroll_hit = 1'b0;
    case (it.kind)
      KIND_BEGIN_NL: begin
        cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
        if (cursor_pos > CELLS) begin
          cursor_pos = CELLS;
        end
        same_line = 1'b0;
        bs_held = 1'b0;
      end
      KIND_BEGIN_SL: begin
        same_line = 1'b1;
        bs_held = 1'b0;
      end
      KIND_CHAR: begin
        if (bs_held) begin
          bs_held = 1'b0;
          if (it.ch == LETTER_N) begin
            if (same_line) begin
              cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
            end else begin
              line_feed_scrolling();
            end
            done = 1'b1;
          end else if (same_line) begin
            put_clipped(BACKSLASH_CH, bs_color);
          end else begin
            put_scrolling(BACKSLASH_CH, bs_color);
          end
        end
        if (!done) begin
          if (same_line && cursor_pos >= CELLS - 1) begin
            drop = 1'b1;
          end else if (it.ch == BACKSLASH_CH) begin
            bs_held = 1'b1;
            bs_color = it.color;
          end else if (it.ch == NEWLINE_CH) begin
            if (same_line) begin
              cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
            end else begin
              line_feed_scrolling();
            end
          end else if (same_line) begin
            put_clipped(it.ch, it.color);
          end else begin
            put_scrolling(it.ch, it.color);
          end
        end
      end
      KIND_END: begin
        if (bs_held) begin
          bs_held = 1'b0;
          if (same_line) begin
            put_clipped(BACKSLASH_CH, bs_color);
          end else begin
            put_scrolling(BACKSLASH_CH, bs_color);
          end
        end
      end
      KIND_SET: begin
        cursor_pos = (it.pos > CELLS) ? CELLS : it.pos;
        bs_held = 1'b0;
      end
      KIND_READ: begin
        if (it.pos < CELLS) begin
          entry = screen_mem[ring_index(it.pos)];
          res.rchar = entry[CHAR_W-1:0];
          res.rattr = entry[CELL_W-1:CHAR_W];
        end
      end
      default: begin
      end
    endcase
    res.cursor = POS_W'(cursor_pos);
    res.scrolled = scroll_hit;
    res.dropped = drop;
    return res;
  endfunction

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input logic [CHAR_W-1:0] color, input logic [POS_W-1:0] pos);
    console_item_t it;
    it.kind = kind;
    it.ch = ch;
    it.color = color;
    it.pos = pos;
    pending_items.push_back(it);
    if (kind <= KIND_READ) begin
      queued_count++;
    end
  endtask

  // mostly near the last row, where scrolls and drops happen
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      return POS_W'($urandom_range(CELLS, CELLS - 2 * COLUMNS));
    end else if (r < 60) begin
      return POS_W'($urandom_range((1 << POS_W) - 1, CELLS));
    end
    return POS_W'($urandom_range(CELLS));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      return NEWLINE_CH;
    end else if (r < 30) begin
      return BACKSLASH_CH;
    end else if (r < 45) begin
      return LETTER_N;
    end
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic queue_directed();
    queue_item(KIND_READ, 8'h00, 8'h00, POS_W'(0));
    queue_item(KIND_READ, 8'hFF, 8'hFF, '1);
    queue_item(KIND_BEGIN_NL, 8'h00, 8'h00, '0);
    queue_item(KIND_CHAR, 8'h41, 8'hFF, '0);
    queue_item(KIND_CHAR, 8'h00, 8'h00, '1);
    queue_item(KIND_CHAR, 8'hFF, 8'h3C, '0);
    queue_item(KIND_CHAR, NEWLINE_CH, 8'h12, '0);
    queue_item(KIND_CHAR, BACKSLASH_CH, 8'h1E, '0);
    queue_item(KIND_CHAR, LETTER_N, 8'h2F, '0);
    queue_item(KIND_CHAR, BACKSLASH_CH, 8'h4A, '0);
    queue_item(KIND_CHAR, 8'h78, 8'h5B, '0);
    queue_item(KIND_CHAR, BACKSLASH_CH, 8'h6C, '0);
    queue_item(KIND_END, 8'h00, 8'h00, '0);
    queue_item(KIND_CHAR, 8'h5A, 8'h81, '0);
    queue_item(KIND_READ, 8'h00, 8'h00, POS_W'(COLUMNS));
    queue_item(KIND_CHAR, BACKSLASH_CH, 8'h92, '0);
    queue_item(KIND_SET, 8'h00, 8'h00, '1);
    queue_item(KIND_CHAR, 8'h71, 8'hA3, '0);
    queue_item(KIND_BEGIN_SL, 8'h00, 8'h00, '0);
    queue_item(KIND_SET, 8'h00, 8'h00, POS_W'(CELLS - 2));
    queue_item(KIND_CHAR, BACKSLASH_CH, 8'h55, '0);
    queue_item(KIND_CHAR, 8'h79, 8'hB4, '0);
    queue_item(KIND_CHAR, NEWLINE_CH, 8'hC5, '0);
    queue_item(KIND_SPARE_LO, 8'hFF, 8'hFF, '1);
    queue_item(KIND_SPARE_HI, 8'h00, 8'h00, '0);
    queue_item(KIND_BEGIN_NL, 8'h00, 8'h00, '0);
    queue_item(KIND_READ, 8'h00, 8'h00, POS_W'(CELLS - 2));
  endtask

  // framed strings with random content, with some noise around them
  task automatic queue_random_traffic(input int target);
    int stop_at;
    int n;
    stop_at = queued_count + target;
    while (queued_count < stop_at) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(2) == 0) begin
          queue_item(KIND_SET, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                     pick_position());
        end
        queue_item($urandom_range(1) ? KIND_BEGIN_NL : KIND_BEGIN_SL,
                   CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                   POS_W'($urandom_range((1 << POS_W) - 1)));
        n = $urandom_range(14, 1);
        repeat (n) begin
          queue_item(KIND_CHAR, pick_char(), CHAR_W'($urandom_range(255)),
                     POS_W'($urandom_range((1 << POS_W) - 1)));
        end
        if ($urandom_range(9) != 0) begin
          queue_item(KIND_END, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                     POS_W'($urandom_range((1 << POS_W) - 1)));
        end
        if ($urandom_range(1) == 0) begin
          queue_item(KIND_READ, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                     pick_position());
        end
      end else begin
        queue_item(KIND_W'($urandom_range(KIND_SPARE_HI)), pick_char(),
                   CHAR_W'($urandom_range(255)), pick_position());
      end
    end
  endtask

  task automatic wait_idle();
    while (!(pending_items.size() == 0 && !in_valid && items_taken == results_checked)) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // item driver
  always @(posedge clk) begin
    console_item_t nxt;
    console_result_t want;
    bit sent;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      sent = in_valid && in_ready;
      if (sent) begin
        want = console_step({in_kind, in_ch, in_color, in_position});
        due_results.push_back(want);
        items_taken++;
        scroll_total += want.scrolled;
        drop_total += want.dropped;
        read_total += (in_kind == KIND_READ);
      end
      if (!in_valid || sent) begin
        if (drain_wait && items_taken == results_checked) begin
          drain_wait = 1'b0;
        end
        if (!drain_wait && pending_items.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_kind <= nxt.kind;
          in_ch <= nxt.ch;
          in_color <= nxt.color;
          in_position <= nxt.pos;
          in_valid <= 1'b1;
          sent_count++;
          if (sent_count % 257 == 0) begin
            drain_wait = 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no item pending, cursor", out_cursor_now, 0);
        end else begin
          want = due_results.pop_front();
          if (out_cursor_now !== want.cursor) begin
            report_mismatch("cursor_now", out_cursor_now, want.cursor);
          end
          if (out_read_char !== want.rchar) begin
            report_mismatch("read_char", out_read_char, want.rchar);
          end
          if (out_read_attr !== want.rattr) begin
            report_mismatch("read_attr", out_read_attr, want.rattr);
          end
          if (out_scrolled !== want.scrolled) begin
            report_mismatch("scrolled", out_scrolled, want.scrolled);
          end
          if (out_dropped !== want.dropped) begin
            report_mismatch("dropped", out_dropped, want.dropped);
          end
        end
        results_checked <= results_checked + 1;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int send_pcts[PHASES];
    int recv_pcts[PHASES];
    logic [CHAR_W-1:0] attrs[PHASES];
    logic [PDATA_W-1:0] rdata;
    send_pcts = '{0, 83, 0, 13};
    recv_pcts = '{0, 0, 83, 13};
    attrs = '{8'hFF, 8'h00, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255))};
    for (int i = 0; i < CELLS; i++) begin
      screen_mem[i] = {RESET_ATTR, SPACE_CH};
    end
    top_row = 0;
    cursor_pos = 0;
    same_line = 1'b0;
    bs_held = 1'b0;
    bs_color = '0;
    blank_attr = RESET_ATTR;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_idle();
    for (int p = 0; p < PHASES; p++) begin
      apb_access(1'b1, BLANK_ATTR_ADDR, PDATA_W'(attrs[p]), rdata);
      blank_attr = attrs[p];
      apb_access(1'b0, BLANK_ATTR_ADDR, '0, rdata);
      if (rdata[CHAR_W-1:0] !== blank_attr) begin
        report_mismatch("blank_attribute readback", rdata[CHAR_W-1:0], blank_attr);
      end
      send_idle_pct <= send_pcts[p];
      recv_stall_pct <= recv_pcts[p];
      @(posedge clk);
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();
    end

    repeat (COLUMNS * 3) @(posedge clk);
    if (due_results.size() != 0) begin
      report_mismatch("results never delivered", 0, due_results.size());
    end
    $display("covered %0d items over %0d blank attribute settings and idling mixes",
             items_taken, PHASES);
    $display("%0d items scrolled, %0d dropped at screen end, %0d cell reads",
             scroll_total, drop_total, read_total);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
